// ----- rtl/dq_pkg.sv -----
`timescale 1ns / 1ps

package dq_pkg;

    // Operation codes carried on the kind field
    typedef logic [2:0] kind_t;

    localparam kind_t KIND_PUSH_BACK  = 3'd0;
    localparam kind_t KIND_PUSH_FRONT = 3'd1;
    localparam kind_t KIND_POP_FRONT  = 3'd2;
    localparam kind_t KIND_POP_BACK   = 3'd3;
    localparam kind_t KIND_PEEK_FRONT = 3'd4;
    localparam kind_t KIND_PEEK_BACK  = 3'd5;
    localparam kind_t KIND_STATUS     = 3'd6;

    // Result status codes
    typedef logic [1:0] stat_t;

    localparam stat_t STAT_DONE  = 2'd0;
    localparam stat_t STAT_EMPTY = 2'd1;
    localparam stat_t STAT_FULL  = 2'd2;

    localparam int WORD_W  = 32;
    localparam int FILL_W  = 11;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // take the input beat: update pointers, store, read
        logic load_out;  // move the finished result into the output register
    } dq_cmd_t;

endpackage

// ----- rtl/dq_ctrl.sv -----
`timescale 1ns / 1ps

module dq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output dq_pkg::dq_cmd_t   cmd
);

    typedef enum logic [1:0]
    {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // Take a beat only while no operation is in flight
    assign in_stall     = (state_reg != S_IDLE);
    assign out_free     = !out_valid_reg || !out_stall;
    assign cmd.accept   = in_valid && (state_reg == S_IDLE);
    assign cmd.load_out = (state_reg == S_EXEC) && out_free;
    assign out_valid    = out_valid_reg;

    // Advance after the store read; hold while the output register is occupied and stalled
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Set valid on load, drop it when the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == S_EXEC))
        else $error("accepted beat did not start execution");

    a_exec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EXEC) && out_valid_reg && out_stall) |=> (state_reg == S_EXEC))
        else $error("result left execution while output was blocked");

    a_load_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !in_stall || (state_reg == S_EXEC))
        else $error("output loaded outside execution");
`endif

endmodule

// ----- rtl/dq_dpath.sv -----
`timescale 1ns / 1ps

module dq_dpath
#(
    parameter int DEPTH = 1024
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  dq_pkg::dq_cmd_t                    cmd,
    input  dq_pkg::kind_t                      kind,
    input  logic signed [dq_pkg::WORD_W-1:0]   push_word,
    output dq_pkg::stat_t                      status,
    output logic signed [dq_pkg::WORD_W-1:0]   out_word,
    output logic [dq_pkg::FILL_W-1:0]          fill_count,
    output logic                               is_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [dq_pkg::WORD_W-1:0] store_mem [DEPTH];

    logic [PW-1:0] front_reg;
    logic [PW-1:0] front_next;
    logic [PW-1:0] back_reg;
    logic [PW-1:0] back_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic [PW-1:0] front_up;
    logic [PW-1:0] front_down;
    logic [PW-1:0] back_up;
    logic [PW-1:0] back_down;

    logic          full;
    logic          empty;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [PW-1:0] rd_addr;
    logic          rd_ok;
    dq_pkg::stat_t stat_calc;

    logic [dq_pkg::WORD_W-1:0] rd_data_reg;
    logic                      rd_ok_reg;
    dq_pkg::stat_t             stat_reg;
    logic [dq_pkg::WORD_W-1:0] out_word_reg;
    dq_pkg::stat_t             out_stat_reg;
    logic [CW-1:0]             out_count_reg;

    // Ring pointer neighbors
    assign front_up   = (front_reg == PTR_LAST) ? '0 : front_reg + 1'b1;
    assign front_down = (front_reg == '0) ? PTR_LAST : front_reg - 1'b1;
    assign back_up    = (back_reg == PTR_LAST) ? '0 : back_reg + 1'b1;
    assign back_down  = (back_reg == '0) ? PTR_LAST : back_reg - 1'b1;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);

    // Decode the operation into pointer, count and store actions
    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = back_up;
        rd_addr    = front_reg;
        rd_ok      = 1'b0;
        stat_calc  = dq_pkg::STAT_DONE;
        unique case (kind)
            dq_pkg::KIND_PUSH_BACK,
            dq_pkg::KIND_PUSH_FRONT:
            begin
                if (full)
                begin
                    stat_calc = dq_pkg::STAT_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (kind == dq_pkg::KIND_PUSH_BACK)
                    begin
                        back_next = back_up;
                        wr_addr   = back_up;
                    end
                    else
                    begin
                        front_next = front_down;
                        wr_addr    = front_down;
                    end
                end
            end
            dq_pkg::KIND_POP_FRONT,
            dq_pkg::KIND_PEEK_FRONT:
            begin
                rd_addr = front_reg;
                if (empty)
                begin
                    stat_calc = dq_pkg::STAT_EMPTY;
                end
                else
                begin
                    rd_ok = 1'b1;
                    if (kind == dq_pkg::KIND_POP_FRONT)
                    begin
                        front_next = front_up;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            dq_pkg::KIND_POP_BACK,
            dq_pkg::KIND_PEEK_BACK:
            begin
                rd_addr = back_reg;
                if (empty)
                begin
                    stat_calc = dq_pkg::STAT_EMPTY;
                end
                else
                begin
                    rd_ok = 1'b1;
                    if (kind == dq_pkg::KIND_POP_BACK)
                    begin
                        back_next  = back_down;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                stat_calc = dq_pkg::STAT_DONE;
            end
        endcase
    end

    // Ring store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
        begin
            store_mem[wr_addr] <= push_word;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // Advance pointers and count on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= PTR_LAST;
            count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    // Hold per-item result fields while the store read completes
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_ok_reg <= rd_ok;
            stat_reg  <= stat_calc;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_stat_reg  <= stat_reg;
            out_word_reg  <= rd_ok_reg ? rd_data_reg : '0;
            out_count_reg <= count_reg;
        end
    end

    assign status     = out_stat_reg;
    assign out_word   = $signed(out_word_reg);
    assign fill_count = dq_pkg::FILL_W'(out_count_reg);
    assign is_empty   = (out_count_reg == '0);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("word count above depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (front_reg == back_up))
        else $error("pointers out of step on empty queue");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && full && (kind == dq_pkg::KIND_PUSH_BACK
            || kind == dq_pkg::KIND_PUSH_FRONT)) |=> $stable(count_reg))
        else $error("push on full store changed the count");
`endif

endmodule

// ----- rtl/double_ended_queue_top.sv -----
`timescale 1ns / 1ps
// An accepted input beat is read from the ring store into a registered read port, then
//   moved into the output register; no new input beat is taken until that move, and a
//   blocked output register holds execution.
// Reset (rst_n, async, active low): count cleared, front pointer 0, back pointer
//   DEPTH-1, output empty; store contents are not cleared and no clearing pass runs.
module double_ended_queue_top
#(
    parameter int DEPTH = 1024
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [2:0]                         kind,
    input  logic signed [31:0]                 push_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic signed [31:0]                 out_word,
    output logic [10:0]                        fill_count,
    output logic                               is_empty
);

    dq_pkg::dq_cmd_t cmd;

    // Sequencing of beats
    dq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Pointers, count, ring store and result register
    dq_dpath
    #(
        .DEPTH (DEPTH)
    )
    u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .kind       (kind),
        .push_word  (push_word),
        .status     (status),
        .out_word   (out_word),
        .fill_count (fill_count),
        .is_empty   (is_empty)
    );

endmodule
